// File: design/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants for the top-K score selector
// Field widths, sizing constants, beat types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

	localparam int MAX_WINNERS = 16;
	localparam int MAX_ITEMS   = 1024;
	localparam int SCORE_WIDTH = 32;

	localparam int IDX_W  = 10;
	localparam int CFG_W  = 5;
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int K_W    = $clog2(MAX_WINNERS + 1);
	localparam int POS_W  = (MAX_WINNERS > 1) ? $clog2(MAX_WINNERS) : 1;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam logic [0:0] REG_WINNERS_COUNT = 1'b0;

	typedef struct packed {
		logic signed [SCORE_WIDTH-1:0] score;
		logic                          last_item;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]              winner_index;
		logic signed [SCORE_WIDTH-1:0] winner_score;
		logic                          last_winner;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0]              index;
		logic signed [SCORE_WIDTH-1:0] score;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_REPL_CHK,
		ST_REPL_CMP,
		ST_WRITE_NEW,
		ST_FINISH,
		ST_EMIT
	} state_t;

	function automatic logic [K_W-1:0] clamp_k(input logic [CFG_W-1:0] v);
		logic [K_W-1:0] r;
		if (v == '0) begin
			r = K_W'(1);
		end else if (int'(v) > MAX_WINNERS) begin
			r = K_W'(MAX_WINNERS);
		end else begin
			r = K_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/tks_ram.sv
// ----------------------------------------------------------------------------
// tks_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: design/top_k_score_selector.sv
// ----------------------------------------------------------------------------
// top_k_score_selector: streaming top-K selection over a population
// Keeps the best K scores in an ascending list held in a small RAM and emits
// them best first on the item marked last.
// ----------------------------------------------------------------------------
// Per item: acceptance in idle, then one list step per cycle through the single
// RAM read port and one shared score comparator for an insertion or replacement,
// plus a wrap-up state.
// On the last item: n results follow back to back (n = min(K, items seen)),
// registered from the emit states after wrap-up; busy drops with the final result.
// Asynchronous reset clears the sequencer, the item count and K (to 1); the
// list RAM is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module top_k_score_selector
	import tks_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire item_t             item,
	output logic                   result_valid,
	output result_t                result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	state_t state_q, state_d;

	logic [CFG_W-1:0] winners_count_q;
	logic [K_W-1:0]   active_k_q;
	logic [CNT_W-1:0] items_seen_q;
	logic [POS_W-1:0] pos_q;
	logic signed [SCORE_WIDTH-1:0] score_q;
	logic [IDX_W-1:0] idx_q;
	logic             last_q;
	result_t          result_q;
	logic             result_valid_q;

	logic             accept;
	logic [K_W-1:0]   k_eff;
	logic             in_range;
	logic             filling;
	logic [K_W-1:0]   n_out;
	entry_t           new_entry;
	entry_t           rd_entry;
	logic [$bits(entry_t)-1:0] rdata;
	logic signed [SCORE_WIDTH-1:0] cmp_a, cmp_b;
	logic             gt;

	logic             we;
	logic [POS_W-1:0] waddr, raddr;
	entry_t           wdata;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			winners_count_q <= CFG_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == REG_WINNERS_COUNT) begin
			winners_count_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINNERS_COUNT) begin
			prdata = DATA_W'(winners_count_q);
		end
	end

	// ---------------- shared compare unit ----------------
	assign rd_entry  = entry_t'(rdata);
	assign new_entry = '{index: idx_q, score: score_q};

	// The fill walk asks whether the stored entry outranks the new one;
	// the replace walk asks the opposite.
	always_comb begin
		if (state_q == ST_FILL) begin
			cmp_a = rd_entry.score;
			cmp_b = score_q;
		end else begin
			cmp_a = score_q;
			cmp_b = rd_entry.score;
		end
	end
	assign gt = cmp_a > cmp_b;

	assign accept   = start && (state_q == ST_IDLE);
	assign k_eff    = (items_seen_q == '0) ? clamp_k(winners_count_q) : active_k_q;
	assign in_range = items_seen_q < CNT_W'(MAX_ITEMS);
	assign filling  = items_seen_q < CNT_W'(k_eff);
	assign n_out    = (items_seen_q < CNT_W'(active_k_q)) ? K_W'(items_seen_q) : active_k_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = new_entry;
		raddr   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!in_range) begin
						state_d = ST_FINISH;
					end else if (filling) begin
						if (items_seen_q == '0) begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = '{index: items_seen_q[IDX_W-1:0], score: item.score};
							state_d = ST_FINISH;
						end else begin
							raddr   = POS_W'(items_seen_q - CNT_W'(1));
							state_d = ST_FILL;
						end
					end else begin
						raddr   = '0;
						state_d = ST_REPL_CHK;
					end
				end
			end
			ST_FILL: begin
				we = 1'b1;
				if (gt) begin
					// shift the larger entry up one slot
					wdata = rd_entry;
					if (pos_q == POS_W'(1)) begin
						state_d = ST_WRITE_NEW;
					end else begin
						raddr = pos_q - POS_W'(2);
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_REPL_CHK: begin
				if (gt) begin
					if (active_k_q == K_W'(1)) begin
						we      = 1'b1;
						waddr   = '0;
						state_d = ST_FINISH;
					end else begin
						raddr   = POS_W'(1);
						state_d = ST_REPL_CMP;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_REPL_CMP: begin
				we = 1'b1;
				if (gt) begin
					// drop the smaller entry down one slot
					wdata = rd_entry;
					if (K_W'(pos_q) + K_W'(2) == active_k_q) begin
						state_d = ST_WRITE_NEW;
					end else begin
						raddr = pos_q + POS_W'(2);
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_WRITE_NEW: begin
				we      = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (last_q) begin
					raddr   = POS_W'(n_out - K_W'(1));
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (pos_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					raddr = pos_q - POS_W'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- control counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_seen_q   <= '0;
			active_k_q     <= K_W'(1);
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == ST_EMIT);
			if (accept) begin
				if (items_seen_q == '0) begin
					active_k_q <= k_eff;
				end
				if (in_range) begin
					items_seen_q <= items_seen_q + CNT_W'(1);
				end
			end else if (state_q == ST_FINISH && last_q) begin
				items_seen_q <= '0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					score_q <= item.score;
					last_q  <= item.last_item;
					idx_q   <= items_seen_q[IDX_W-1:0];
					pos_q   <= filling ? POS_W'(items_seen_q) : '0;
				end
			end
			ST_FILL: begin
				if (gt) begin
					pos_q <= pos_q - POS_W'(1);
				end
			end
			ST_REPL_CMP: begin
				if (gt) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			ST_FINISH: begin
				pos_q <= POS_W'(n_out - K_W'(1));
			end
			ST_EMIT: begin
				result_q <= '{winner_index: rd_entry.index,
				              winner_score: rd_entry.score,
				              last_winner:  (pos_q == '0)};
				pos_q    <= pos_q - POS_W'(1);
			end
			default: begin
			end
		endcase
	end

	tks_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_WINNERS)
	) u_list (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// File: design/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker: port-level checks for the top-K score selector
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_checker
	import tks_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    start,
	input wire logic    busy,
	input wire logic    result_valid,
	input wire result_t result
);

	// an accepted beat always raises busy in the cycle after it
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	// results only come out of a command in progress
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a command in progress");

	// winners stream back to back until the lowest one
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_winner |=> result_valid)
		else $error("gap inside a winner burst");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_winner |=> !result_valid)
		else $error("result strobe after the final winner");

	a_busy_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_winner |-> busy)
		else $error("block idle in the middle of a winner burst");

endmodule

bind top_k_score_selector tks_checker u_tks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire
